### sv/assert_macros.svh
// Concurrent assertion helpers, clocked on clk_i.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check while out of reset.
`define RSDZ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check at every edge, reset included.
`define RSDZ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

### sv/rsdz_pkg.sv
package rsdz_pkg;

  localparam int unsigned SampleWidthDef = 16;
  localparam int unsigned DzW            = 15;
  localparam int unsigned OutW           = 16;
  localparam int unsigned LenFrac        = 7;
  localparam int unsigned GainFrac       = 30;
  localparam int unsigned GainW          = GainFrac + 1;
  localparam int unsigned OutQW          = 15;
  localparam int unsigned OutScale       = 16;

  localparam logic [DzW-1:0]  LeftDzRst  = DzW'(7849);
  localparam logic [DzW-1:0]  RightDzRst = DzW'(8689);
  localparam logic [OutW-1:0] OutMax     = OutW'(32767);

  typedef enum logic [0:0] {
    REG_LEFT_DZ  = 1'b0,
    REG_RIGHT_DZ = 1'b1
  } cfg_reg_e;

endpackage

### sv/rsdz_sqrt_cell.sv
module rsdz_sqrt_cell #(
  parameter int unsigned RW  = 23,
  parameter int unsigned VW  = 46,
  parameter int unsigned SBW = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  logic [VW-1:0]  rad_i,
  input  logic [RW:0]    rem_i,
  input  logic [RW-1:0]  root_i,
  input  logic [SBW-1:0] side_i,
  output logic           valid_o,
  output logic [VW-1:0]  rad_o,
  output logic [RW:0]    rem_o,
  output logic [RW-1:0]  root_o,
  output logic [SBW-1:0] side_o
);
  logic [RW+1:0] r4, trial, delta;
  logic          ge;
  logic          valid_q;
  logic [VW-1:0] rad_q;
  logic [RW:0]   rem_q, rem_d;
  logic [RW-1:0] root_q, root_d;
  logic [SBW-1:0] side_q;

  // One root bit per cell: bring down two radicand bits, try root*4+1.
  assign r4    = {rem_i[RW-1:0], rad_i[VW-1 -: 2]};
  assign trial = {root_i, 2'b01};
  assign ge    = (r4 >= trial);
  assign delta = r4 - trial;
  assign rem_d  = ge ? delta[RW:0] : r4[RW:0];
  assign root_d = {root_i[RW-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= {rad_i[VW-3:0], 2'b00};
    rem_q  <= rem_d;
    root_q <= root_d;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign rad_o   = rad_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign side_o  = side_q;
endmodule

### sv/rsdz_div_cell.sv
module rsdz_div_cell #(
  parameter int unsigned DW  = 23,
  parameter int unsigned NW  = 31,
  parameter int unsigned QW  = 31,
  parameter int unsigned SBW = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  logic [DW-1:0]  rem_i,
  input  logic [NW-1:0]  num_i,
  input  logic [DW-1:0]  den_i,
  input  logic [QW-1:0]  q_i,
  input  logic [SBW-1:0] side_i,
  output logic           valid_o,
  output logic [DW-1:0]  rem_o,
  output logic [NW-1:0]  num_o,
  output logic [DW-1:0]  den_o,
  output logic [QW-1:0]  q_o,
  output logic [SBW-1:0] side_o
);
  logic [DW:0]    sh, delta;
  logic           ge;
  logic           valid_q;
  logic [DW-1:0]  rem_q, den_q;
  logic [NW-1:0]  num_q;
  logic [QW-1:0]  q_q;
  logic [SBW-1:0] side_q;

  // Restoring step: shift in the next dividend bit, subtract when it fits.
  assign sh    = {rem_i, num_i[NW-1]};
  assign ge    = (sh >= {1'b0, den_i});
  assign delta = sh - {1'b0, den_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= ge ? delta[DW-1:0] : sh[DW-1:0];
    num_q  <= {num_i[NW-2:0], 1'b0};
    den_q  <= den_i;
    q_q    <= {q_i[QW-2:0], ge};
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign num_o   = num_q;
  assign den_o   = den_q;
  assign q_o     = q_q;
  assign side_o  = side_q;
endmodule

### sv/radial_stick_dead_zone.sv
// Throughput: one word per cycle; busy_o stays low and start_i may be high every cycle.
// Latency is set by the square-root cell chain (one root bit per cell), the
// 31-cell gain divider and the two 15-cell output dividers. No output stall.
// Reset: asynchronous, active low; clears pipeline valids and restores both radii.
module radial_stick_dead_zone #(
  parameter int unsigned SAMPLE_WIDTH = rsdz_pkg::SampleWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic signed [SAMPLE_WIDTH-1:0] stick_x_i,
  input  logic signed [SAMPLE_WIDTH-1:0] stick_y_i,
  input  logic                           use_left_i,
  input  logic                           cfg_we_i,
  input  logic [0:0]                     cfg_idx_i,
  input  logic [rsdz_pkg::DzW-1:0]       cfg_data_i,
  output logic                           done_o,
  output logic signed [rsdz_pkg::OutW-1:0] out_x_o,
  output logic signed [rsdz_pkg::OutW-1:0] out_y_o,
  output logic                           inside_dead_zone_o
);
  import rsdz_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned W    = SAMPLE_WIDTH;
  localparam int unsigned SqW  = 2 * W;
  localparam int unsigned CmpW = (SqW > 2 * DzW) ? SqW : 2 * DzW;
  localparam int unsigned SatW = (W > DzW + 1) ? W : DzW + 1;
  localparam int unsigned N    = W + LenFrac;         // root width
  localparam int unsigned VW   = 2 * N;               // radicand width
  localparam int unsigned LcW  = (N > DzW + LenFrac) ? N : DzW + LenFrac;
  localparam int unsigned PW   = W + GainW;           // component * gain
  localparam int unsigned DW   = W - 1 + OutScale;    // output divisor width
  localparam logic [W-2:0] FullScale = {(W-1){1'b1}};
  localparam int unsigned Sb1W = 3 * W + 18;
  localparam int unsigned Sb2W = 3 * W + 3;
  localparam int unsigned Sb3W = 7;
  localparam int unsigned Lat  = 3 + N + 1 + GainW + 2 + OutQW + 1;

  // ---------------------------------------------------------------
  // Radius registers: the user writes them only while the pipe is empty; the block does not enforce this.
  // ---------------------------------------------------------------
  logic [DzW-1:0] left_dz_q, right_dz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_dz_q  <= LeftDzRst;
      right_dz_q <= RightDzRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_LEFT_DZ:  left_dz_q  <= cfg_data_i;
        REG_RIGHT_DZ: right_dz_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A new word may enter every cycle.
  assign busy_o = 1'b0;

  // ---------------------------------------------------------------
  // Stage 0: magnitudes, signs and the selected radius.
  // ---------------------------------------------------------------
  logic           v0_q;
  logic [W-1:0]   mx0_q, my0_q;
  logic           nx0_q, ny0_q;
  logic [DzW-1:0] dz0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    nx0_q <= stick_x_i[W-1];
    ny0_q <= stick_y_i[W-1];
    mx0_q <= stick_x_i[W-1] ? (~stick_x_i + 1'b1) : stick_x_i;
    my0_q <= stick_y_i[W-1] ? (~stick_y_i + 1'b1) : stick_y_i;
    dz0_q <= use_left_i ? left_dz_q : right_dz_q;
  end

  // ---------------------------------------------------------------
  // Stage 1: squares.
  // ---------------------------------------------------------------
  logic             v1_q;
  logic [SqW-1:0]   sqx1_q, sqy1_q;
  logic [2*DzW-1:0] dzsq1_q;
  logic [W-1:0]     mx1_q, my1_q;
  logic             nx1_q, ny1_q;
  logic [DzW-1:0]   dz1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sqx1_q  <= SqW'(mx0_q) * SqW'(mx0_q);
    sqy1_q  <= SqW'(my0_q) * SqW'(my0_q);
    dzsq1_q <= (2*DzW)'(dz0_q) * (2*DzW)'(dz0_q);
    mx1_q   <= mx0_q;
    my1_q   <= my0_q;
    nx1_q   <= nx0_q;
    ny1_q   <= ny0_q;
    dz1_q   <= dz0_q;
  end

  // ---------------------------------------------------------------
  // Stage 2: squared length, dead-zone test, remap denominator.
  // ---------------------------------------------------------------
  logic           v2_q;
  logic [SqW-1:0] sum2_q;
  logic           inside2_q, sat2_q;
  logic [W-2:0]   denom2_q;
  logic [W-1:0]   mx2_q, my2_q;
  logic           nx2_q, ny2_q;
  logic [DzW-1:0] dz2_q;
  logic [SqW-1:0] sum1;

  assign sum1 = sqx1_q + sqy1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sum2_q    <= sum1;
    inside2_q <= (CmpW'(sum1) <= CmpW'(dzsq1_q));
    // Radius at or past full scale: no room to remap, saturate instead.
    sat2_q    <= (SatW'(dz1_q) >= SatW'(FullScale));
    denom2_q  <= FullScale - dz1_q[W-2:0];
    mx2_q     <= mx1_q;
    my2_q     <= my1_q;
    nx2_q     <= nx1_q;
    ny2_q     <= ny1_q;
    dz2_q     <= dz1_q;
  end

  // ---------------------------------------------------------------
  // Square-root chain: one root bit per cell, length with 7 fraction bits.
  // ---------------------------------------------------------------
  logic            sq_v    [N+1];
  logic [VW-1:0]   sq_rad  [N+1];
  logic [N:0]      sq_rem  [N+1];
  logic [N-1:0]    sq_root [N+1];
  logic [Sb1W-1:0] sq_sb   [N+1];

  assign sq_v[0]    = v2_q;
  assign sq_rad[0]  = {sum2_q, (2*LenFrac)'(0)};
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_sb[0]   = {mx2_q, my2_q, nx2_q, ny2_q, inside2_q, sat2_q, dz2_q, denom2_q};

  for (genvar i = 0; i < N; i++) begin : g_sqrt
    rsdz_sqrt_cell #(.RW(N), .VW(VW), .SBW(Sb1W)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_v[i]),
      .rad_i   (sq_rad[i]),
      .rem_i   (sq_rem[i]),
      .root_i  (sq_root[i]),
      .side_i  (sq_sb[i]),
      .valid_o (sq_v[i+1]),
      .rad_o   (sq_rad[i+1]),
      .rem_o   (sq_rem[i+1]),
      .root_o  (sq_root[i+1]),
      .side_o  (sq_sb[i+1])
    );
  end

  // ---------------------------------------------------------------
  // Length minus radius, clamped at zero.
  // ---------------------------------------------------------------
  logic [W-1:0]   mx3, my3;
  logic           nx3, ny3, inside3, sat3;
  logic [DzW-1:0] dz3;
  logic [W-2:0]   denom3;
  logic [LcW-1:0] len_ext, dzq_ext;

  assign {mx3, my3, nx3, ny3, inside3, sat3, dz3, denom3} = sq_sb[N];
  assign len_ext = LcW'(sq_root[N]);
  assign dzq_ext = LcW'({dz3, (LenFrac)'(0)});

  logic            v4_q;
  logic [N-1:0]    len4_q, diff4_q;
  logic [Sb2W-1:0] sb4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= sq_v[N];
    end
  end

  always_ff @(posedge clk_i) begin
    len4_q  <= sq_root[N];
    diff4_q <= (len_ext > dzq_ext) ? N'(len_ext - dzq_ext) : '0;
    sb4_q   <= {mx3, my3, nx3, ny3, inside3, sat3, denom3};
  end

  // ---------------------------------------------------------------
  // Gain chain: floor(diff * 2^30 / len), one quotient bit per cell.
  // ---------------------------------------------------------------
  logic            gn_v   [GainW+1];
  logic [N-1:0]    gn_rem [GainW+1];
  logic [GainW-1:0] gn_num [GainW+1];
  logic [N-1:0]    gn_den [GainW+1];
  logic [GainW-1:0] gn_q   [GainW+1];
  logic [Sb2W-1:0] gn_sb  [GainW+1];

  // diff <= len, so the dividend's top part (diff >> 1) is already below len.
  assign gn_v[0]   = v4_q;
  assign gn_rem[0] = {1'b0, diff4_q[N-1:1]};
  assign gn_num[0] = {diff4_q[0], (GainFrac)'(0)};
  assign gn_den[0] = len4_q;
  assign gn_q[0]   = '0;
  assign gn_sb[0]  = sb4_q;

  for (genvar i = 0; i < GainW; i++) begin : g_gain
    rsdz_div_cell #(.DW(N), .NW(GainW), .QW(GainW), .SBW(Sb2W)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (gn_v[i]),
      .rem_i   (gn_rem[i]),
      .num_i   (gn_num[i]),
      .den_i   (gn_den[i]),
      .q_i     (gn_q[i]),
      .side_i  (gn_sb[i]),
      .valid_o (gn_v[i+1]),
      .rem_o   (gn_rem[i+1]),
      .num_o   (gn_num[i+1]),
      .den_o   (gn_den[i+1]),
      .q_o     (gn_q[i+1]),
      .side_o  (gn_sb[i+1])
    );
  end

  // ---------------------------------------------------------------
  // Multiply each component magnitude by the gain.
  // ---------------------------------------------------------------
  logic [W-1:0] mx5, my5;
  logic         nx5, ny5, inside5, sat5;
  logic [W-2:0] denom5;

  assign {mx5, my5, nx5, ny5, inside5, sat5, denom5} = gn_sb[GainW];

  logic          v6_q;
  logic [PW-1:0] px6_q, py6_q;
  logic          nx6_q, ny6_q, inside6_q, sat6_q, mxnz6_q, mynz6_q;
  logic [W-2:0]  denom6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else begin
      v6_q <= gn_v[GainW];
    end
  end

  always_ff @(posedge clk_i) begin
    px6_q     <= PW'(mx5) * PW'(gn_q[GainW]);
    py6_q     <= PW'(my5) * PW'(gn_q[GainW]);
    nx6_q     <= nx5;
    ny6_q     <= ny5;
    inside6_q <= inside5;
    sat6_q    <= sat5;
    mxnz6_q   <= (mx5 != '0);
    mynz6_q   <= (my5 != '0);
    denom6_q  <= denom5;
  end

  // ---------------------------------------------------------------
  // Overflow check and dividend split for the output dividers.
  // A quotient of 2^15 or more saturates, so 15 quotient bits remain.
  // ---------------------------------------------------------------
  logic          v7_q;
  logic          ovx7_q, ovy7_q;
  logic [DW-1:0] remx7_q, remy7_q, den7_q;
  logic [OutQW-1:0] numx7_q, numy7_q;
  logic [Sb3W-2:0]  sb7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else begin
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ovx7_q  <= (px6_q[PW-1:GainW] >= {1'b0, denom6_q});
    ovy7_q  <= (py6_q[PW-1:GainW] >= {1'b0, denom6_q});
    remx7_q <= px6_q[OutQW +: DW];
    remy7_q <= py6_q[OutQW +: DW];
    numx7_q <= px6_q[OutQW-1:0];
    numy7_q <= py6_q[OutQW-1:0];
    den7_q  <= {denom6_q, (OutScale)'(0)};
    sb7_q   <= {nx6_q, ny6_q, inside6_q, sat6_q, mxnz6_q, mynz6_q};
  end

  // ---------------------------------------------------------------
  // Output divider lanes, X and Y side by side.
  // ---------------------------------------------------------------
  logic             ox_v   [OutQW+1];
  logic [DW-1:0]    ox_rem [OutQW+1];
  logic [OutQW-1:0] ox_num [OutQW+1];
  logic [DW-1:0]    ox_den [OutQW+1];
  logic [OutQW-1:0] ox_q   [OutQW+1];
  logic [Sb3W-1:0]  ox_sb  [OutQW+1];
  logic             oy_v   [OutQW+1];
  logic [DW-1:0]    oy_rem [OutQW+1];
  logic [OutQW-1:0] oy_num [OutQW+1];
  logic [DW-1:0]    oy_den [OutQW+1];
  logic [OutQW-1:0] oy_q   [OutQW+1];
  logic             oy_sb  [OutQW+1];

  assign ox_v[0]   = v7_q;
  assign ox_rem[0] = remx7_q;
  assign ox_num[0] = numx7_q;
  assign ox_den[0] = den7_q;
  assign ox_q[0]   = '0;
  assign ox_sb[0]  = {sb7_q, ovx7_q};
  assign oy_v[0]   = v7_q;
  assign oy_rem[0] = remy7_q;
  assign oy_num[0] = numy7_q;
  assign oy_den[0] = den7_q;
  assign oy_q[0]   = '0;
  assign oy_sb[0]  = ovy7_q;

  for (genvar i = 0; i < OutQW; i++) begin : g_out
    rsdz_div_cell #(.DW(DW), .NW(OutQW), .QW(OutQW), .SBW(Sb3W)) u_x (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (ox_v[i]),
      .rem_i   (ox_rem[i]),
      .num_i   (ox_num[i]),
      .den_i   (ox_den[i]),
      .q_i     (ox_q[i]),
      .side_i  (ox_sb[i]),
      .valid_o (ox_v[i+1]),
      .rem_o   (ox_rem[i+1]),
      .num_o   (ox_num[i+1]),
      .den_o   (ox_den[i+1]),
      .q_o     (ox_q[i+1]),
      .side_o  (ox_sb[i+1])
    );
    rsdz_div_cell #(.DW(DW), .NW(OutQW), .QW(OutQW), .SBW(1)) u_y (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (oy_v[i]),
      .rem_i   (oy_rem[i]),
      .num_i   (oy_num[i]),
      .den_i   (oy_den[i]),
      .q_i     (oy_q[i]),
      .side_i  (oy_sb[i]),
      .valid_o (oy_v[i+1]),
      .rem_o   (oy_rem[i+1]),
      .num_o   (oy_num[i+1]),
      .den_o   (oy_den[i+1]),
      .q_o     (oy_q[i+1]),
      .side_o  (oy_sb[i+1])
    );
  end

  // ---------------------------------------------------------------
  // Final select: dead zone, full-scale radius, overflow, then sign.
  // ---------------------------------------------------------------
  logic            nx8, ny8, inside8, sat8, mxnz8, mynz8, ovx8, ovy8;
  logic [OutW-1:0] magx, magy, resx, resy;

  assign {nx8, ny8, inside8, sat8, mxnz8, mynz8, ovx8} = ox_sb[OutQW];
  assign ovy8 = oy_sb[OutQW];

  always_comb begin
    if (sat8) begin
      magx = mxnz8 ? OutMax : '0;
      magy = mynz8 ? OutMax : '0;
    end else begin
      magx = ovx8 ? OutMax : {1'b0, ox_q[OutQW]};
      magy = ovy8 ? OutMax : {1'b0, oy_q[OutQW]};
    end
    resx = nx8 ? (~magx + 1'b1) : magx;
    resy = ny8 ? (~magy + 1'b1) : magy;
    if (inside8) begin
      resx = '0;
      resy = '0;
    end
  end

  logic            done_q;
  logic [OutW-1:0] outx_q, outy_q;
  logic            inside_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ox_v[OutQW];
    end
  end

  always_ff @(posedge clk_i) begin
    outx_q   <= resx;
    outy_q   <= resy;
    inside_q <= inside8;
  end

  assign done_o             = done_q;
  assign out_x_o            = outx_q;
  assign out_y_o            = outy_q;
  assign inside_dead_zone_o = inside_q;

  // ---------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------
  `RSDZ_ASSERT(a_lanes_aligned, ox_v[OutQW] == oy_v[OutQW], "output lanes out of step")
  `RSDZ_ASSERT(a_latency, start_i && !busy_o |-> ##Lat done_o, "result missing after accept")
  `RSDZ_ASSERT(a_dz_zero, done_o && inside_dead_zone_o |-> out_x_o == '0 && out_y_o == '0,
    "nonzero output inside dead zone")
  `RSDZ_ASSERT(a_no_min,
    done_o |-> out_x_o != {1'b1, (OutW-1)'(0)} && out_y_o != {1'b1, (OutW-1)'(0)},
    "output beyond saturation limit")
endmodule

### bench/rsdz_checker.sv
module rsdz_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic                             busy_o,
  input  logic signed [15:0]               stick_x_i,
  input  logic signed [15:0]               stick_y_i,
  input  logic                             use_left_i,
  input  logic                             cfg_we_i,
  input  logic [0:0]                       cfg_idx_i,
  input  logic [rsdz_pkg::DzW-1:0]         cfg_data_i,
  input  logic                             done_o,
  input  logic signed [rsdz_pkg::OutW-1:0] out_x_o,
  input  logic signed [rsdz_pkg::OutW-1:0] out_y_o,
  input  logic                             inside_dead_zone_o,
  output int                               fail_cnt_o,
  output int                               pending_o,
  output int                               checked_o
);
  import rsdz_pkg::*;

  typedef struct packed {
    logic signed [OutW-1:0] x;
    logic signed [OutW-1:0] y;
    logic                   dz_hit;
  } stick_out_t;

  localparam longint unsigned FullScale = 32767;

  stick_out_t         expected_q[$];
  logic [DzW-1:0]     left_dz, right_dz;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [OutW-1:0] signed_sat(longint unsigned mag, logic neg);
    logic [OutW-1:0] m;
    if (mag > 32767) mag = 32767;
    m = mag[OutW-1:0];
    return neg ? -m : m;
  endfunction

  function automatic stick_out_t rescale_stick(logic signed [15:0] x, logic signed [15:0] y,
                                               longint unsigned dz);
    stick_out_t      r;
    longint unsigned mx, my, sum, len, dzq, diff, gain, dv;
    mx  = x[15] ? 64'(-32'(x)) : 64'(x);
    my  = y[15] ? 64'(-32'(y)) : 64'(y);
    sum = mx * mx + my * my;
    r   = '0;
    if (sum <= dz * dz) begin
      r.dz_hit = 1'b1;
    end else if (dz >= FullScale) begin
      // radius at or past full scale: push every nonzero axis to the rail
      r.x = signed_sat(mx != 0 ? 32767 : 0, x[15]);
      r.y = signed_sat(my != 0 ? 32767 : 0, y[15]);
    end else begin
      len  = int_sqrt(sum << 14);
      dzq  = dz << 7;
      diff = (len > dzq) ? len - dzq : 0;
      gain = (diff << 30) / len;
      dv   = (FullScale - dz) << 16;
      r.x  = signed_sat((mx * gain) / dv, x[15]);
      r.y  = signed_sat((my * gain) / dv, y[15]);
    end
    return r;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    stick_out_t e;
    if (!rst_ni) begin
      left_dz    <= LeftDzRst;
      right_dz   <= RightDzRst;
      fail_cnt_o <= 0;
      checked_o  <= 0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_LEFT_DZ) left_dz <= cfg_data_i;
        else                          right_dz <= cfg_data_i;
      end
      if (start_i && !busy_o)
        expected_q.push_back(rescale_stick(stick_x_i, stick_y_i,
                                           use_left_i ? left_dz : right_dz));
      if (done_o) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected word x=%0d y=%0d inside=%0b", $time,
                   out_x_o, out_y_o, inside_dead_zone_o);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          e = expected_q.pop_front();
          checked_o <= checked_o + 1;
          if (e.x !== out_x_o || e.y !== out_y_o || e.dz_hit !== inside_dead_zone_o) begin
            $display("%0t: mismatch expected x=%0d y=%0d inside=%0b, got x=%0d y=%0d inside=%0b",
                     $time, e.x, e.y, e.dz_hit, out_x_o, out_y_o, inside_dead_zone_o);
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
    end
  end

endmodule

### bench/tb_radial_stick_dead_zone.sv
module tb_radial_stick_dead_zone;
  import rsdz_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int DrainWait  = 90;   // extra wait after the last pending result

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start_i = 1'b0;
  logic                   busy_o;
  logic signed [15:0]     stick_x_i = '0;
  logic signed [15:0]     stick_y_i = '0;
  logic                   use_left_i = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [0:0]             cfg_idx_i = REG_LEFT_DZ;
  logic [DzW-1:0]         cfg_data_i = '0;
  logic                   done_o;
  logic signed [OutW-1:0] out_x_o, out_y_o;
  logic                   inside_dead_zone_o;

  int fail_cnt, pending, checked;
  int words_sent = 0;
  int settings   = 0;
  int cycles     = 0;
  bit quiet      = 1'b0;    // no random gaps while set
  logic [DzW-1:0] cur_left = LeftDzRst, cur_right = RightDzRst;

  always #4 clk_i = ~clk_i;

  radial_stick_dead_zone i_dut (.*);

  rsdz_checker i_chk (
    .fail_cnt_o(fail_cnt), .pending_o(pending), .checked_o(checked), .*
  );

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Present one word; hold start high until the block takes it.
  task automatic send_word(logic signed [15:0] x, logic signed [15:0] y, logic left);
    logic b;
    if (!quiet && $urandom_range(99) < 7) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start_i    <= 1'b1;
    stick_x_i  <= x;
    stick_y_i  <= y;
    use_left_i <= left;
    do begin
      @(negedge clk_i);
      b = busy_o;
      @(posedge clk_i);
    end while (b);
    words_sent++;
  endtask

  // Drop start and let every word in flight come out.
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // Write both radii; only called with the pipeline empty.
  task automatic set_radii(logic [DzW-1:0] l, logic [DzW-1:0] r);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_LEFT_DZ;
    cfg_data_i <= l;
    @(posedge clk_i);
    cfg_idx_i  <= REG_RIGHT_DZ;
    cfg_data_i <= r;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
    cur_left  = l;
    cur_right = r;
    settings++;
  endtask

  // Random word: near the selected radius (4 in 10), anywhere (4 in 10) or small (2 in 10).
  task automatic random_word();
    logic            left;
    int              dz, kind, x, y;
    left = $urandom_range(1);
    dz   = left ? cur_left : cur_right;
    kind = $urandom_range(9);
    if (kind < 4) begin
      // hug the dead-zone edge along a random axis mix
      x = dz + $signed($urandom_range(6)) - 3;
      y = $urandom_range(40);
      if ($urandom_range(1)) begin x = y; y = dz + $signed($urandom_range(6)) - 3; end
      if (x > 32767) x = 32767;
      if (y > 32767) y = 32767;
      if ($urandom_range(1)) x = -x;
      if ($urandom_range(1)) y = -y;
    end else if (kind < 8) begin
      x = $signed(16'($urandom));
      y = $signed(16'($urandom));
    end else begin
      x = $signed($urandom_range(200)) - 100;
      y = $signed($urandom_range(200)) - 100;
    end
    send_word(16'(x), 16'(y), left);
  endtask

  task automatic random_phase(int n);
    repeat (n) random_word();
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset radii, extremes, edge of the dead zone, both sticks.
    send_word(16'sd0, 16'sd0, 1'b1);
    send_word(-16'sd32768, -16'sd32768, 1'b1);
    send_word(16'sd32767, 16'sd32767, 1'b0);
    send_word(16'sd32767, 16'sd0, 1'b0);
    send_word(16'sd0, -16'sd32768, 1'b1);
    send_word(-16'sd32768, 16'sd32767, 1'b0);
    send_word(16'sd7849, 16'sd0, 1'b1);     // exactly on the left radius
    send_word(16'sd7850, 16'sd0, 1'b1);     // just outside
    send_word(16'sd0, -16'sd8689, 1'b0);    // exactly on the right radius
    send_word(16'sd0, -16'sd8690, 1'b0);
    send_word(16'sd4710, 16'sd6280, 1'b1);  // 3-4-5 triangle just outside the left radius
    send_word(-16'sd1, 16'sd1, 1'b0);
    drain();

    // Zero radius: every nonzero sample is outside.
    set_radii('0, '0);
    send_word(16'sd0, 16'sd0, 1'b1);
    send_word(16'sd1, 16'sd0, 1'b1);
    send_word(-16'sd1, -16'sd1, 1'b0);
    send_word(-16'sd32768, 16'sd0, 1'b0);
    drain();

    // Left radius at full scale, so outside points on the left stick hit the rails.
    set_radii(15'h7FFF, 15'd16384);
    send_word(16'sd32767, 16'sd32767, 1'b1);
    send_word(-16'sd32768, 16'sd0, 1'b1);
    send_word(16'sd0, 16'sd1, 1'b1);
    send_word(16'sd16384, 16'sd0, 1'b0);
    send_word(16'sd16385, -16'sd3, 1'b0);
    drain();

    random_phase(150);
    set_radii('0, 15'd16384);
    random_phase(150);
    // Long stretch with no gaps at all.
    quiet = 1'b1;
    set_radii(15'($urandom_range(16384)), 15'($urandom_range(16384)));
    random_phase(200);
    quiet = 1'b0;
    set_radii(15'($urandom), 15'($urandom));
    random_phase(150);
    set_radii(LeftDzRst, RightDzRst);
    random_phase(150);
    set_radii(15'($urandom_range(64)), 15'($urandom_range(16000, 16384)));
    random_phase(130);

    $display("Sent %0d stick words over %0d radius settings; %0d results checked.",
             words_sent, settings + 1, checked);
    if (fail_cnt == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/rsdz_pkg.sv
sv/rsdz_sqrt_cell.sv
sv/rsdz_div_cell.sv
sv/radial_stick_dead_zone.sv
bench/rsdz_checker.sv
bench/tb_radial_stick_dead_zone.sv
